FILE: sv/tanorm_pkg.sv
// ----------------------------------------------------------------------------
// tanorm_pkg
// shared widths, payload words and cell data types for the absolute unit normal
// ----------------------------------------------------------------------------
`default_nettype none

package tanorm_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 15;
	localparam int IN_W       = 16;
	localparam int OUT_W      = 16;

	localparam int EDGE_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * EDGE_W;
	localparam int CP_W   = PROD_W;
	localparam int SQ_W   = 2 * CP_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int ROOT_W = SUM_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int DR_W   = ROOT_W + 1;
	localparam int Q_W    = FRAC_BITS + 1;

	// 1.0 in the quotient format
	localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

	localparam int FRONT_STAGES = 5;
	localparam int SQRT_CELLS   = ROOT_W;
	localparam int DIV_CELLS    = Q_W;
	localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_CELLS + DIV_CELLS + 1;

	typedef struct packed {
		logic [IN_W-1:0] a_x;
		logic [IN_W-1:0] a_y;
		logic [IN_W-1:0] a_z;
		logic [IN_W-1:0] b_x;
		logic [IN_W-1:0] b_y;
		logic [IN_W-1:0] b_z;
		logic [IN_W-1:0] c_x;
		logic [IN_W-1:0] c_y;
		logic [IN_W-1:0] c_z;
	} vtx_t;

	typedef struct packed {
		logic [OUT_W-1:0] normal_x;
		logic [OUT_W-1:0] normal_y;
		logic [OUT_W-1:0] normal_z;
		logic             degenerate;
	} nrm_t;

	// front end result: abs cross product and its squared length
	typedef struct packed {
		logic [2:0][CP_W-1:0] cp;
		logic [SUM_W-1:0]     sum;
		logic                 degen;
	} front_t;

	// word handed along the square root chain
	typedef struct packed {
		logic [SUM_W-1:0]     rad;
		logic [REM_W-1:0]     rem;
		logic [ROOT_W-1:0]    root;
		logic [2:0][CP_W-1:0] cp;
		logic                 degen;
	} sq_t;

	// word handed along the divider chain
	typedef struct packed {
		logic [ROOT_W-1:0]    den;
		logic [2:0][DR_W-1:0] r;
		logic [2:0][Q_W-1:0]  q;
		logic                 degen;
	} dv_t;

endpackage

`default_nettype wire

FILE: sv/tanorm_front.sv
// ----------------------------------------------------------------------------
// tanorm_front
// edges, cross product, absolute values and squared length in five stages
// ----------------------------------------------------------------------------
`default_nettype none

module tanorm_front (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire tanorm_pkg::vtx_t  vtx,
	output tanorm_pkg::front_t     fr
);

	logic signed [tanorm_pkg::EDGE_W-1:0] e1_s1 [3];
	logic signed [tanorm_pkg::EDGE_W-1:0] e2_s1 [3];
	logic signed [tanorm_pkg::PROD_W-1:0] p_s2 [6];
	logic [tanorm_pkg::CP_W-1:0]          cp_s3 [3];
	logic [tanorm_pkg::CP_W-1:0]          cp_s4 [3];
	logic [tanorm_pkg::SQ_W-1:0]          sq_s4 [3];
	tanorm_pkg::front_t                   fr_s5;

	logic signed [tanorm_pkg::EDGE_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	logic signed [tanorm_pkg::PROD_W:0]   d [3];

	assign ax = tanorm_pkg::EDGE_W'($signed(vtx.a_x[tanorm_pkg::COORD_BITS-1:0]));
	assign ay = tanorm_pkg::EDGE_W'($signed(vtx.a_y[tanorm_pkg::COORD_BITS-1:0]));
	assign az = tanorm_pkg::EDGE_W'($signed(vtx.a_z[tanorm_pkg::COORD_BITS-1:0]));
	assign bx = tanorm_pkg::EDGE_W'($signed(vtx.b_x[tanorm_pkg::COORD_BITS-1:0]));
	assign by = tanorm_pkg::EDGE_W'($signed(vtx.b_y[tanorm_pkg::COORD_BITS-1:0]));
	assign bz = tanorm_pkg::EDGE_W'($signed(vtx.b_z[tanorm_pkg::COORD_BITS-1:0]));
	assign cx = tanorm_pkg::EDGE_W'($signed(vtx.c_x[tanorm_pkg::COORD_BITS-1:0]));
	assign cy = tanorm_pkg::EDGE_W'($signed(vtx.c_y[tanorm_pkg::COORD_BITS-1:0]));
	assign cz = tanorm_pkg::EDGE_W'($signed(vtx.c_z[tanorm_pkg::COORD_BITS-1:0]));

	always_comb begin
		d[0] = (tanorm_pkg::PROD_W+1)'(p_s2[0]) - (tanorm_pkg::PROD_W+1)'(p_s2[1]);
		d[1] = (tanorm_pkg::PROD_W+1)'(p_s2[2]) - (tanorm_pkg::PROD_W+1)'(p_s2[3]);
		d[2] = (tanorm_pkg::PROD_W+1)'(p_s2[4]) - (tanorm_pkg::PROD_W+1)'(p_s2[5]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1[0] <= ax - bx;
			e1_s1[1] <= ay - by;
			e1_s1[2] <= az - bz;
			e2_s1[0] <= ax - cx;
			e2_s1[1] <= ay - cy;
			e2_s1[2] <= az - cz;

			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];

			for (int i = 0; i < 3; i++) begin
				cp_s3[i] <= d[i][tanorm_pkg::PROD_W] ? tanorm_pkg::CP_W'(-d[i])
				                                     : tanorm_pkg::CP_W'(d[i]);
				cp_s4[i] <= cp_s3[i];
				sq_s4[i] <= tanorm_pkg::SQ_W'(cp_s3[i] * cp_s3[i]);
				fr_s5.cp[i] <= cp_s4[i];
			end

			fr_s5.sum   <= tanorm_pkg::SUM_W'(sq_s4[0]) + tanorm_pkg::SUM_W'(sq_s4[1])
			             + tanorm_pkg::SUM_W'(sq_s4[2]);
			fr_s5.degen <= (cp_s4[0] == '0) && (cp_s4[1] == '0) && (cp_s4[2] == '0);
		end
	end

	assign fr = fr_s5;

endmodule

`default_nettype wire

FILE: sv/tanorm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tanorm_sqrt_cell
// one root bit per cell, two radicand bits shifted in
// ----------------------------------------------------------------------------
`default_nettype none

module tanorm_sqrt_cell (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire tanorm_pkg::sq_t  din,
	output tanorm_pkg::sq_t       dout
);

	tanorm_pkg::sq_t          d_q;
	logic [tanorm_pkg::REM_W-1:0] rem_sh;
	logic [tanorm_pkg::REM_W-1:0] trial;
	logic                         take;

	always_comb begin
		rem_sh = {din.rem[tanorm_pkg::REM_W-3:0], din.rad[tanorm_pkg::SUM_W-1 -: 2]};
		trial  = {din.root, 2'b01};
		take   = rem_sh >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q.rad   <= {din.rad[tanorm_pkg::SUM_W-3:0], 2'b00};
			d_q.rem   <= take ? rem_sh - trial : rem_sh;
			d_q.root  <= {din.root[tanorm_pkg::ROOT_W-2:0], take};
			d_q.cp    <= din.cp;
			d_q.degen <= din.degen;
		end
	end

	assign dout = d_q;

endmodule

`default_nettype wire

FILE: sv/tanorm_div_cell.sv
// ----------------------------------------------------------------------------
// tanorm_div_cell
// one restoring quotient bit per cell for all three components
// ----------------------------------------------------------------------------
`default_nettype none

module tanorm_div_cell (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire tanorm_pkg::dv_t  din,
	output tanorm_pkg::dv_t       dout
);

	tanorm_pkg::dv_t                 d_q;
	logic [2:0]                      ge;
	logic [2:0][tanorm_pkg::DR_W-1:0] rn;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ge[i] = din.r[i] >= tanorm_pkg::DR_W'(din.den);
			rn[i] = ge[i] ? din.r[i] - tanorm_pkg::DR_W'(din.den) : din.r[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_q.r[i] <= {rn[i][tanorm_pkg::DR_W-2:0], 1'b0};
				d_q.q[i] <= {din.q[i][tanorm_pkg::Q_W-2:0], ge[i]};
			end
			d_q.den   <= din.den;
			d_q.degen <= din.degen;
		end
	end

	assign dout = d_q;

endmodule

`default_nettype wire

FILE: sv/triangle_abs_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_abs_unit_normal
// absolute unit face normal of a triangle; while not stalled, one word per cycle
// ----------------------------------------------------------------------------
// pipeline from vertex word to normal word: 5 front stages, one
//   cell per root bit, one cell per quotient bit, output register
// throughput: one word per cycle while the output is not stalled; the whole row of cells advances together
// reset: clears only the valid bits of the pipeline; payload is not reset
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_abs_unit_normal (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             vertex_valid,
	output logic                  vertex_ready,
	input  wire tanorm_pkg::vtx_t vertices,
	output logic                  normal_valid,
	input  wire logic             normal_ready,
	output tanorm_pkg::nrm_t      normal
);

	// one valid bit per stage, shifted along with the data
	logic [tanorm_pkg::PIPE_DEPTH-1:0] valid_q;
	logic                              en;

	tanorm_pkg::front_t fr;
	tanorm_pkg::sq_t    sq [tanorm_pkg::SQRT_CELLS+1];
	tanorm_pkg::dv_t    dv [tanorm_pkg::DIV_CELLS+1];
	tanorm_pkg::nrm_t   out_q;
	logic [tanorm_pkg::OUT_W-1:0] nq [3];

	// the row moves whenever the output word is empty or being taken
	assign en           = !valid_q[tanorm_pkg::PIPE_DEPTH-1] || normal_ready;
	assign vertex_ready = en;
	assign normal_valid = valid_q[tanorm_pkg::PIPE_DEPTH-1];
	assign normal       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[tanorm_pkg::PIPE_DEPTH-2:0], vertex_valid};
		end
	end

	// edges, cross product, squares, sum
	tanorm_front u_front (
		.clk (clk),
		.en  (en),
		.vtx (vertices),
		.fr  (fr)
	);

	// square root chain: radicand enters with empty remainder and root
	always_comb begin
		sq[0].rad   = fr.sum;
		sq[0].rem   = '0;
		sq[0].root  = '0;
		sq[0].cp    = fr.cp;
		sq[0].degen = fr.degen;
	end

	for (genvar k = 0; k < tanorm_pkg::SQRT_CELLS; k++) begin : g_sqrt
		tanorm_sqrt_cell u_cell (
			.clk  (clk),
			.en   (en),
			.din  (sq[k]),
			.dout (sq[k+1])
		);
	end

	// divider chain: each component divided by the magnitude
	always_comb begin
		dv[0].den = sq[tanorm_pkg::SQRT_CELLS].root;
		for (int i = 0; i < 3; i++) begin
			dv[0].r[i] = tanorm_pkg::DR_W'(sq[tanorm_pkg::SQRT_CELLS].cp[i]);
			dv[0].q[i] = '0;
		end
		dv[0].degen = sq[tanorm_pkg::SQRT_CELLS].degen;
	end

	for (genvar k = 0; k < tanorm_pkg::DIV_CELLS; k++) begin : g_div
		tanorm_div_cell u_cell (
			.clk  (clk),
			.en   (en),
			.din  (dv[k]),
			.dout (dv[k+1])
		);
	end

	// clamp at one, zero on a degenerate triangle
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv[tanorm_pkg::DIV_CELLS].degen) begin
				nq[i] = '0;
			end else if (dv[tanorm_pkg::DIV_CELLS].q[i] > tanorm_pkg::Q_ONE) begin
				nq[i] = tanorm_pkg::OUT_W'(tanorm_pkg::Q_ONE);
			end else begin
				nq[i] = tanorm_pkg::OUT_W'(dv[tanorm_pkg::DIV_CELLS].q[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.normal_x   <= nq[0];
			out_q.normal_y   <= nq[1];
			out_q.normal_z   <= nq[2];
			out_q.degenerate <= dv[tanorm_pkg::DIV_CELLS].degen;
		end
	end

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives random and corner-case triangles through the unit normal pipeline
// and checks each normal word against a predictor of its own
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int LATENCY   = 57;
	localparam int WDOG_MAX  = 20000;
	localparam int RAND_WORDS = 1530;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vertex_valid = 1'b0;
	logic vertex_ready;
	tanorm_pkg::vtx_t vertices = '0;
	logic normal_valid;
	logic normal_ready = 1'b0;
	tanorm_pkg::nrm_t normal;

	tanorm_pkg::vtx_t pending_tris[$];
	tanorm_pkg::nrm_t expected_normals[$];
	int   fail_count = 0;
	int   idle_cycles = 0;
	logic hold_send = 1'b0;

	// clock: 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	triangle_abs_unit_normal i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.vertices     (vertices),
		.normal_valid (normal_valid),
		.normal_ready (normal_ready),
		.normal       (normal)
	);

	// floor square root of a sum of three squares, bit by bit from the top
	function automatic logic [63:0] floor_root(logic [127:0] v);
		logic [63:0] res;
		logic [63:0] cand;
		res = '0;
		for (int b = 50; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= v)
				res = cand;
		end
		return res;
	endfunction

	// one component: floor(c * 2^15 / m) clamped at 1.0
	function automatic logic [15:0] unit_part(logic [63:0] c, logic [63:0] m);
		logic [127:0] q;
		q = ({64'd0, c} << tanorm_pkg::FRAC_BITS) / {64'd0, m};
		if (q > (128'd1 << tanorm_pkg::FRAC_BITS))
			q = 128'd1 << tanorm_pkg::FRAC_BITS;
		return q[15:0];
	endfunction

	// expected normal word for one triangle
	function automatic tanorm_pkg::nrm_t predict_normal(tanorm_pkg::vtx_t t);
		logic signed [63:0] a[3], b[3], c[3], e1[3], e2[3], d[3];
		logic [63:0]  cp[3];
		logic [127:0] sum;
		logic [63:0]  mag;
		tanorm_pkg::nrm_t n;
		a = '{64'(signed'(t.a_x)), 64'(signed'(t.a_y)), 64'(signed'(t.a_z))};
		b = '{64'(signed'(t.b_x)), 64'(signed'(t.b_y)), 64'(signed'(t.b_z))};
		c = '{64'(signed'(t.c_x)), 64'(signed'(t.c_y)), 64'(signed'(t.c_z))};
		for (int i = 0; i < 3; i++) begin
			e1[i] = a[i] - b[i];
			e2[i] = a[i] - c[i];
		end
		d[0] = e1[1] * e2[2] - e1[2] * e2[1];
		d[1] = e1[2] * e2[0] - e1[0] * e2[2];
		d[2] = e1[0] * e2[1] - e1[1] * e2[0];
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			cp[i] = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
			sum += {64'd0, cp[i]} * {64'd0, cp[i]};
		end
		n = '0;
		if (sum == 0) begin
			n.degenerate = 1'b1;
			return n;
		end
		mag = floor_root(sum);
		n.normal_x = unit_part(cp[0], mag);
		n.normal_y = unit_part(cp[1], mag);
		n.normal_z = unit_part(cp[2], mag);
		return n;
	endfunction

	function automatic logic [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'(32'($urandom_range(0, 6)) - 3);
			1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic tanorm_pkg::vtx_t rand_tri();
		tanorm_pkg::vtx_t t;
		int mode;
		mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 9) < 2 ? 1 : 2);
		t = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode)};
		// now and then collapse the triangle: repeated vertices
		case ($urandom_range(0, 19))
			0: {t.b_x, t.b_y, t.b_z} = {t.a_x, t.a_y, t.a_z};
			1: {t.c_x, t.c_y, t.c_z} = {t.b_x, t.b_y, t.b_z};
			2: t = {t.a_x, t.a_y, t.a_z, t.a_x, t.a_y, t.a_z, t.a_x, t.a_y, t.a_z};
			default: ;
		endcase
		return t;
	endfunction

	// mostly no gap at all, often a short one, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report(string what, tanorm_pkg::nrm_t got, tanorm_pkg::nrm_t want);
		$display("normal word %s: got %h/%h/%h/%b want %h/%h/%h/%b", what,
			got.normal_x, got.normal_y, got.normal_z, got.degenerate,
			want.normal_x, want.normal_y, want.normal_z, want.degenerate);
		fail_count++;
	endtask

	// stimulus: directed corners first, then random triangles
	initial begin
		pending_tris.push_back('0);
		pending_tris.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
			16'h7fff, 16'h8000, 16'h7fff});
		pending_tris.push_back({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
			16'h8000, 16'h7fff, 16'h8000});
		pending_tris.push_back({16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff,
			16'h0000, 16'h8000, 16'h8000});
		pending_tris.push_back({16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0});
		pending_tris.push_back({16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1});
		pending_tris.push_back({16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1});
		pending_tris.push_back({16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd2});
		pending_tris.push_back({16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd1, 16'd2, 16'd3});
		pending_tris.push_back({16'd0, 16'd0, 16'd0, 16'd1, 16'd2, 16'd3, 16'hffff, 16'hfffe, 16'hfffd});
		pending_tris.push_back({16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff});
		pending_tris.push_back({16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000});
		pending_tris.push_back({16'hffff, 16'h5555, 16'haaaa, 16'h0001, 16'haaaa, 16'h5555,
			16'h1234, 16'hedcb, 16'h7f00});
		pending_tris.push_back({16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0});
		pending_tris.push_back({16'd0, 16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 16'd0, 16'd4, 16'd12});
		for (int i = 0; i < RAND_WORDS; i++)
			pending_tris.push_back(rand_tri());
	end

	// reset, then let the driver run; pause the sender once until drained
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_tris.size() < 800);
		@(posedge clk);
		hold_send <= 1'b1;
		wait (expected_normals.size() == 0 && !vertex_valid);
		@(posedge clk);
		hold_send <= 1'b0;
	end

	// driver: vertex words from the pending queue with random gaps
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (vertex_valid && vertex_ready) begin
				expected_normals.push_back(predict_normal(vertices));
				send_gap = gap_len();
			end
			if (!vertex_valid || vertex_ready) begin
				if (send_gap > 0 || hold_send || pending_tris.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					vertex_valid <= 1'b0;
				end else begin
					vertex_valid <= 1'b1;
					vertices <= pending_tris.pop_front();
				end
			end
		end
	end

	// monitor: check normal words and stall the receiver at random
	int recv_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (normal_valid && normal_ready) begin
				if (expected_normals.size() == 0)
					report("without a pending triangle", normal, '0);
				else if (normal !== expected_normals[0])
					report("differs", normal, expected_normals.pop_front());
				else
					void'(expected_normals.pop_front());
				recv_gap = gap_len();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				normal_ready <= 1'b0;
			end else
				normal_ready <= 1'b1;
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((vertex_valid && vertex_ready) || (normal_valid && normal_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("triangle_abs_unit_normal: mismatch");
			$finish;
		end
	end

	// end of run: all sent, all checked, then drain a pipeline's worth
	initial begin
		wait (arst_n);
		wait (pending_tris.size() == 0 && !vertex_valid && expected_normals.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (expected_normals.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("triangle_abs_unit_normal: match");
		else
			$display("triangle_abs_unit_normal: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
